[hw/rtl/tdt_pkg.sv]
`default_nettype none

package tdt_pkg;

   // Field and datapath widths
   localparam int SIZE_W      = 11;
   localparam int LEVEL_W     = 4;
   localparam int FMT_W       = 4;
   localparam int DATA_W      = 64;
   localparam int OFFSET_W    = 22;
   localparam int BYTES_W     = 4;
   localparam int BPT_W       = 6;
   localparam int LOG2_W      = 2;
   localparam int DIM_W       = 4;
   localparam int SUB_W       = 3;
   localparam int PIX_W       = 2 * SIZE_W;
   localparam int BPU_W       = BPT_W + 4;
   localparam int PROD_W      = PIX_W + BPU_W;
   localparam int OFFB_W      = PROD_W - 3;
   localparam int AREA_W      = 2 * SIZE_W;
   localparam int RPROD_W     = AREA_W + BPT_W;
   localparam int REAL_W      = RPROD_W - 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = SIZE_W;

   // Texel format codes
   localparam logic [FMT_W-1:0] FMT_I4     = 4'd0;
   localparam logic [FMT_W-1:0] FMT_I8     = 4'd1;
   localparam logic [FMT_W-1:0] FMT_IA4    = 4'd2;
   localparam logic [FMT_W-1:0] FMT_IA8    = 4'd3;
   localparam logic [FMT_W-1:0] FMT_RGB565 = 4'd7;
   localparam logic [FMT_W-1:0] FMT_RGB5A3 = 4'd8;
   localparam logic [FMT_W-1:0] FMT_RGBA8  = 4'd9;
   localparam logic [FMT_W-1:0] FMT_CMPR   = 4'd10;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TEXEL_FORMAT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MIP_COUNT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_W_LOG2 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_H_LOG2 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_BITS_PER_TEX = 3'd6;

   typedef struct packed {
      logic [FMT_W-1:0]   texel_format;
      logic [SIZE_W-1:0]  image_width;
      logic [SIZE_W-1:0]  image_height;
      logic [LEVEL_W-1:0] mip_count;
      logic [LOG2_W-1:0]  block_width_log2;
      logic [LOG2_W-1:0]  block_height_log2;
      logic [BPT_W-1:0]   bits_per_texel;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      texel_format:      FMT_I8,
      image_width:       11'd1024,
      image_height:      11'd1024,
      mip_count:         4'd1,
      block_width_log2:  2'd3,
      block_height_log2: 2'd2,
      bits_per_texel:    6'd8
   };

   // One walked unit leaving the walk stage
   typedef struct packed {
      logic               valid;
      logic [SIZE_W-1:0]  row;
      logic [SIZE_W-1:0]  col;
      logic [SIZE_W-1:0]  stride;
      logic [LEVEL_W-1:0] level;
      logic               last;
      logic [DATA_W-1:0]  data;
   } unit_type;

   typedef struct packed {
      logic [DATA_W-1:0]  data;
      logic [BYTES_W-1:0] bytes;
   } conv_type;

   // Tile dimension in units: texels, or 4x4 groups in compressed mode
   function automatic logic [DIM_W-1:0] block_dim(logic [LOG2_W-1:0] lg, logic cmpr);
      logic [DIM_W-1:0] b;
      b = DIM_W'(1) << lg;
      if (cmpr) b = b >> 2;
      if (b == '0) b = DIM_W'(1);
      return b;
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] sz,
                                                    int unsigned max_size);
      logic [SIZE_W-1:0] r;
      r = sz;
      if (32'(sz) > max_size) r = SIZE_W'(max_size);
      return r;
   endfunction

   // Reverse the four 2-bit index fields of one byte
   function automatic logic [7:0] swap_pairs(logic [7:0] b);
      return ((b & 8'h03) << 6) | ((b & 8'h0C) << 2) |
             ((b & 8'h30) >> 2) | ((b & 8'hC0) >> 6);
   endfunction

   function automatic conv_type convert(logic [FMT_W-1:0] fmt, logic [DATA_W-1:0] u);
      conv_type c;
      c.data  = '0;
      c.bytes = '0;
      unique case (fmt) inside
         FMT_I4, FMT_I8, FMT_IA4: begin
            c.bytes = BYTES_W'(1);
            c.data  = {56'd0, u[7:0]};
         end
         FMT_IA8, FMT_RGB565, FMT_RGB5A3: begin
            c.bytes = BYTES_W'(2);
            c.data  = {48'd0, u[15:0]};
         end
         FMT_RGBA8: begin
            c.bytes = BYTES_W'(4);
            c.data  = {32'd0, u[31:0]};
         end
         FMT_CMPR: begin
            c.bytes = BYTES_W'(8);
            c.data  = {u[63:32], swap_pairs(u[31:24]), swap_pairs(u[23:16]),
                       swap_pairs(u[15:8]), swap_pairs(u[7:0])};
         end
         default: begin
            c.bytes = '0;
            c.data  = '0;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/tdt_walk.sv]
`default_nettype none

module tdt_walk import tdt_pkg::*; #(
   parameter int MAX_SIZE   = 1024,
   parameter int MAX_LEVELS = 11
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire cfg_type             cfg_next,
   input  wire logic                restart,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [DATA_W-1:0]   req_unit_data,
   input  wire logic                req_source_end,
   input  wire logic                s1_take,
   output unit_type                 s1
);

   logic [SIZE_W-1:0]  tile_col_ff, tile_col_in, tile_row_ff, tile_row_in;
   logic [SUB_W-1:0]   sub_col_ff, sub_col_in, sub_row_ff, sub_row_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [SIZE_W-1:0]  level_width_ff, level_width_in;
   logic [SIZE_W-1:0]  level_height_ff, level_height_in;
   logic               finished_ff, finished_in;
   unit_type           s1_ff, s1_in;

   logic               cmpr, next_cmpr;
   logic [1:0]         next_shift;
   logic [DIM_W-1:0]   bw, bh, step;
   logic [SIZE_W-1:0]  stride, height_span;
   logic [LEVEL_W-1:0] mc, level_sum;
   logic [DIM_W-1:0]   sub_col_sum, sub_row_sum;
   logic [SIZE_W:0]    tile_col_sum, tile_row_sum;
   logic               col_wrap, row_wrap, tcol_wrap, trow_wrap, level_done, last;
   logic               s1_ready, accept, emit;

   // Decode the tile geometry of the current level
   always_comb begin
      cmpr        = (cfg.texel_format == FMT_CMPR);
      next_cmpr   = (cfg_next.texel_format == FMT_CMPR);
      next_shift  = next_cmpr ? 2'd2 : 2'd0;
      bw          = block_dim(cfg.block_width_log2, cmpr);
      bh          = block_dim(cfg.block_height_log2, cmpr);
      stride      = (level_width_ff > SIZE_W'(bw)) ? level_width_ff : SIZE_W'(bw);
      height_span = (level_height_ff > SIZE_W'(bh)) ? level_height_ff : SIZE_W'(bh);
      mc          = (32'(cfg.mip_count) > MAX_LEVELS) ? LEVEL_W'(MAX_LEVELS)
                                                       : cfg.mip_count;
      step        = (cfg.bits_per_texel == BPT_W'(4) && !cmpr) ? DIM_W'(2) : DIM_W'(1);
   end

   // Next position of the walk
   always_comb begin
      sub_col_sum  = DIM_W'(sub_col_ff) + step;
      sub_row_sum  = DIM_W'(sub_row_ff) + DIM_W'(1);
      tile_col_sum = {1'b0, tile_col_ff} + (SIZE_W + 1)'(bw);
      tile_row_sum = {1'b0, tile_row_ff} + (SIZE_W + 1)'(bh);
      level_sum    = level_ff + LEVEL_W'(1);
      col_wrap     = (sub_col_sum >= bw);
      row_wrap     = (sub_row_sum >= bh);
      tcol_wrap    = (tile_col_sum >= {1'b0, stride});
      trow_wrap    = (tile_row_sum >= {1'b0, height_span});
      level_done   = col_wrap && row_wrap && tcol_wrap && trow_wrap && (level_sum >= mc);
      last         = level_done || req_source_end;
   end

   // Handshake: drop words once the walk is finished
   assign s1_ready  = !s1_ff.valid || s1_take;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;
   assign emit      = accept && !finished_ff && (mc != '0);

   // Advance walk counters
   always_comb begin
      tile_col_in     = tile_col_ff;
      tile_row_in     = tile_row_ff;
      sub_col_in      = sub_col_ff;
      sub_row_in      = sub_row_ff;
      level_in        = level_ff;
      level_width_in  = level_width_ff;
      level_height_in = level_height_ff;
      finished_in     = finished_ff;
      if (reset || restart) begin
         tile_col_in     = '0;
         tile_row_in     = '0;
         sub_col_in      = '0;
         sub_row_in      = '0;
         level_in        = '0;
         level_width_in  = clamp_size(cfg_next.image_width, MAX_SIZE) >> next_shift;
         level_height_in = clamp_size(cfg_next.image_height, MAX_SIZE) >> next_shift;
         finished_in     = 1'b0;
      end else if (accept && !finished_ff) begin
         if (mc == '0) begin
            finished_in = 1'b1;
         end else begin
            finished_in = last;
            sub_col_in  = sub_col_sum[SUB_W-1:0];
            if (col_wrap) begin
               sub_col_in = '0;
               sub_row_in = sub_row_sum[SUB_W-1:0];
               if (row_wrap) begin
                  sub_row_in  = '0;
                  tile_col_in = tile_col_sum[SIZE_W-1:0];
                  if (tcol_wrap) begin
                     tile_col_in = '0;
                     tile_row_in = tile_row_sum[SIZE_W-1:0];
                     if (trow_wrap) begin
                        tile_row_in     = '0;
                        level_in        = level_sum;
                        level_width_in  = level_width_ff >> 1;
                        level_height_in = level_height_ff >> 1;
                     end
                  end
               end
            end
         end
      end
   end

   // Load the walk stage register
   always_comb begin
      s1_in = s1_ff;
      if (s1_ready) begin
         s1_in.valid = emit;
         if (emit) begin
            s1_in.row    = tile_row_ff + SIZE_W'(sub_row_ff);
            s1_in.col    = tile_col_ff + SIZE_W'(sub_col_ff);
            s1_in.stride = stride;
            s1_in.level  = level_ff;
            s1_in.last   = last;
            s1_in.data   = req_unit_data;
         end
      end
      if (reset) s1_in.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      tile_col_ff     <= tile_col_in;
      tile_row_ff     <= tile_row_in;
      sub_col_ff      <= sub_col_in;
      sub_row_ff      <= sub_row_in;
      level_ff        <= level_in;
      level_width_ff  <= level_width_in;
      level_height_ff <= level_height_in;
      finished_ff     <= finished_in;
      s1_ff           <= s1_in;
   end

   assign s1 = s1_ff;

endmodule

`default_nettype wire

[hw/rtl/tdt_datapath.sv]
`default_nettype none

module tdt_datapath import tdt_pkg::*; #(
   parameter int MAX_SIZE = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire unit_type            s1,
   output logic                     s1_take,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [OFFSET_W-1:0]      rsp_dest_offset,
   output logic [DATA_W-1:0]        rsp_out_data,
   output logic [BYTES_W-1:0]       rsp_out_bytes,
   output logic [LEVEL_W-1:0]       rsp_mip_level,
   output logic                     rsp_beyond_buffer,
   output logic                     rsp_last
);

   typedef struct packed {
      logic               valid;
      logic [PIX_W-1:0]   pix;
      logic [AREA_W-1:0]  area;
      logic [LEVEL_W-1:0] level;
      logic               last;
      conv_type           conv;
   } s2_type;

   typedef struct packed {
      logic               valid;
      logic [OFFB_W-1:0]  offb;
      logic [REAL_W-1:0]  real_size;
      logic [LEVEL_W-1:0] level;
      logic               last;
      conv_type           conv;
   } s3_type;

   typedef struct packed {
      logic                valid;
      logic [OFFSET_W-1:0] offset;
      logic                beyond;
      logic [LEVEL_W-1:0]  level;
      logic                last;
      conv_type            conv;
   } out_type;

   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   out_type out_ff, out_in;

   logic              out_ready, s3_ready, s2_ready;
   logic [SIZE_W-1:0] lw, lh;
   logic [BPU_W-1:0]  bpu;
   logic [PROD_W-1:0] prod;
   logic [RPROD_W-1:0] rprod;

   // Each stage moves when the one after it has room
   assign out_ready = !out_ff.valid || !rsp_stall;
   assign s3_ready  = !s3_ff.valid || out_ready;
   assign s2_ready  = !s2_ff.valid || s3_ready;
   assign s1_take   = s2_ready;

   // Stage 2: linear texel index, level area, data conversion
   always_comb begin
      lw    = clamp_size(cfg.image_width, MAX_SIZE) >> s1.level;
      lh    = clamp_size(cfg.image_height, MAX_SIZE) >> s1.level;
      s2_in = s2_ff;
      if (s2_ready) begin
         s2_in.valid = s1.valid;
         if (s1.valid) begin
            s2_in.pix   = PIX_W'(s1.row) * PIX_W'(s1.stride) + PIX_W'(s1.col);
            s2_in.area  = AREA_W'(lw) * AREA_W'(lh);
            s2_in.level = s1.level;
            s2_in.last  = s1.last;
            s2_in.conv  = convert(cfg.texel_format, s1.data);
         end
      end
      if (reset) s2_in.valid = 1'b0;
   end

   // Stage 3: scale to bytes
   always_comb begin
      bpu   = (cfg.texel_format == FMT_CMPR) ? {cfg.bits_per_texel, 4'd0}
                                             : BPU_W'(cfg.bits_per_texel);
      prod  = PROD_W'(s2_ff.pix) * PROD_W'(bpu);
      rprod = RPROD_W'(s2_ff.area) * RPROD_W'(cfg.bits_per_texel);
      s3_in = s3_ff;
      if (s3_ready) begin
         s3_in.valid = s2_ff.valid;
         if (s2_ff.valid) begin
            s3_in.offb      = prod[PROD_W-1:3];
            s3_in.real_size = rprod[RPROD_W-1:3];
            s3_in.level     = s2_ff.level;
            s3_in.last      = s2_ff.last;
            s3_in.conv      = s2_ff.conv;
         end
      end
      if (reset) s3_in.valid = 1'b0;
   end

   // Output register: flag offsets past the real buffer
   always_comb begin
      out_in = out_ff;
      if (out_ready) begin
         out_in.valid = s3_ff.valid;
         if (s3_ff.valid) begin
            out_in.offset = s3_ff.offb[OFFSET_W-1:0];
            out_in.beyond = (s3_ff.offb >= OFFB_W'(s3_ff.real_size));
            out_in.level  = s3_ff.level;
            out_in.last   = s3_ff.last;
            out_in.conv   = s3_ff.conv;
         end
      end
      if (reset) out_in.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      out_ff <= out_in;
   end

   assign rsp_valid         = out_ff.valid;
   assign rsp_dest_offset   = out_ff.offset;
   assign rsp_out_data      = out_ff.conv.data;
   assign rsp_out_bytes     = out_ff.conv.bytes;
   assign rsp_mip_level     = out_ff.level;
   assign rsp_beyond_buffer = out_ff.beyond;
   assign rsp_last          = out_ff.last;

endmodule

`default_nettype wire

[hw/rtl/tiled_texture_detiler.sv]
// Block-tiled texture detiler.
// Input channel (req_*): one source unit per word, in tiled stream order, with
// req_source_end marking the last unit of the source. A word is taken at an
// edge with req_valid high and req_stall low.
// Result channel (rsp_*): one word per unit with its byte offset in the linear
// image of its mip level, converted data, byte count, level, a beyond-buffer
// flag, and rsp_last on the final unit. Words after the final unit are taken
// and dropped until a write to a defined register or reset restarts the walk.
// Configuration (csr_*): csr_ready is always high; any write to a defined
// register restarts the walk at level 0. Write only while the block is idle.
// Throughput: one word per cycle while no stall holds the pipe; the walk
// counters advance once per taken word. A result passes the walk register,
// the index/area multiply stage, the byte-scale stage and the output register.
// Reset loads the default registers, clears the walk and empties the pipe.
// When rsp_stall is high the result holds; the pipe keeps taking words until
// every stage is full, then req_stall rises in the same cycle.
`default_nettype none

module tiled_texture_detiler import tdt_pkg::*; #(
   parameter int MAX_SIZE   = 1024,
   parameter int MAX_LEVELS = 11
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [DATA_W-1:0]      req_unit_data,
   input  wire logic                   req_source_end,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [OFFSET_W-1:0]         rsp_dest_offset,
   output logic [DATA_W-1:0]           rsp_out_data,
   output logic [BYTES_W-1:0]          rsp_out_bytes,
   output logic [LEVEL_W-1:0]          rsp_mip_level,
   output logic                        rsp_beyond_buffer,
   output logic                        rsp_last
);

   cfg_type  cfg_ff, cfg_in;
   logic     csr_write, cfg_hit, s1_take;
   unit_type s1;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Decode register writes
   always_comb begin
      cfg_in  = cfg_ff;
      cfg_hit = 1'b0;
      if (reset) begin
         cfg_in = CFG_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TEXEL_FORMAT: begin
               cfg_in.texel_format = csr_wdata[FMT_W-1:0];
               cfg_hit = 1'b1;
            end
            REG_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_wdata[SIZE_W-1:0];
               cfg_hit = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               cfg_in.image_height = csr_wdata[SIZE_W-1:0];
               cfg_hit = 1'b1;
            end
            REG_MIP_COUNT: begin
               cfg_in.mip_count = csr_wdata[LEVEL_W-1:0];
               cfg_hit = 1'b1;
            end
            REG_BLOCK_W_LOG2: begin
               cfg_in.block_width_log2 = csr_wdata[LOG2_W-1:0];
               cfg_hit = 1'b1;
            end
            REG_BLOCK_H_LOG2: begin
               cfg_in.block_height_log2 = csr_wdata[LOG2_W-1:0];
               cfg_hit = 1'b1;
            end
            REG_BITS_PER_TEX: begin
               cfg_in.bits_per_texel = csr_wdata[BPT_W-1:0];
               cfg_hit = 1'b1;
            end
            default: cfg_hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   tdt_walk #(
      .MAX_SIZE   (MAX_SIZE),
      .MAX_LEVELS (MAX_LEVELS)
   ) u_walk (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cfg_next       (cfg_in),
      .restart        (cfg_hit),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_unit_data  (req_unit_data),
      .req_source_end (req_source_end),
      .s1_take        (s1_take),
      .s1             (s1)
   );

   tdt_datapath #(
      .MAX_SIZE (MAX_SIZE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .s1                (s1),
      .s1_take           (s1_take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dest_offset   (rsp_dest_offset),
      .rsp_out_data      (rsp_out_data),
      .rsp_out_bytes     (rsp_out_bytes),
      .rsp_mip_level     (rsp_mip_level),
      .rsp_beyond_buffer (rsp_beyond_buffer),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

[hw/rtl/tdt_checker.sv]
`default_nettype none

module tdt_checker import tdt_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic [DATA_W-1:0]      req_unit_data,
   input  wire logic                   req_source_end,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [OFFSET_W-1:0]    rsp_dest_offset,
   input  wire logic [DATA_W-1:0]      rsp_out_data,
   input  wire logic [BYTES_W-1:0]     rsp_out_bytes,
   input  wire logic [LEVEL_W-1:0]     rsp_mip_level,
   input  wire logic                   rsp_beyond_buffer,
   input  wire logic                   rsp_last
);

   logic done_ff, done_in;

   // Track a delivered final word until the next register write or reset
   always_comb begin
      done_in = done_ff;
      if (reset || (csr_valid && csr_ready)) done_in = 1'b0;
      else if (rsp_valid && !rsp_stall && rsp_last) done_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      done_ff <= done_in;
   end

   // Hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dest_offset) &&
         $stable(rsp_out_data) && $stable(rsp_mip_level) && $stable(rsp_last))
      else $error("stalled result word changed");

   // Empty result channel right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // No result after the final word until a restart
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !rsp_valid)
      else $error("result after final word");

   // Data bits above the byte count stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_out_bytes == 4'd0 && rsp_out_data == 64'd0) ||
         (rsp_out_bytes == 4'd1 && rsp_out_data[63:8] == 56'd0) ||
         (rsp_out_bytes == 4'd2 && rsp_out_data[63:16] == 48'd0) ||
         (rsp_out_bytes == 4'd4 && rsp_out_data[63:32] == 32'd0) ||
         (rsp_out_bytes == 4'd8))
      else $error("result data wider than byte count");

endmodule

bind tiled_texture_detiler tdt_checker u_tdt_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import tdt_pkg::*;

   localparam int unsigned SIZE_CAP     = 1024;
   localparam int unsigned LEVEL_CAP    = 11;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES  = 150;
   localparam int unsigned QUIET_LIMIT  = 1000;
   localparam int unsigned RANDOM_UNITS = 1050;
   localparam int unsigned WALK_CAP     = 240;
   localparam int unsigned WIDE_UNITS   = 250;

   // Index with no register behind it; a write there must change nothing
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              src_end;
   } source_unit_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] dest_offset;
      logic [DATA_W-1:0]   out_data;
      logic [BYTES_W-1:0]  out_bytes;
      logic [LEVEL_W-1:0]  mip_level;
      logic                beyond_buffer;
      logic                last;
   } texel_word_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [DATA_W-1:0]      req_unit_data  = '0;
   logic                   req_source_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [OFFSET_W-1:0]    rsp_dest_offset;
   logic [DATA_W-1:0]      rsp_out_data;
   logic [BYTES_W-1:0]     rsp_out_bytes;
   logic [LEVEL_W-1:0]     rsp_mip_level;
   logic                   rsp_beyond_buffer;
   logic                   rsp_last;

   tiled_texture_detiler dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_unit_data     (req_unit_data),
      .req_source_end    (req_source_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dest_offset   (rsp_dest_offset),
      .rsp_out_data      (rsp_out_data),
      .rsp_out_bytes     (rsp_out_bytes),
      .rsp_mip_level     (rsp_mip_level),
      .rsp_beyond_buffer (rsp_beyond_buffer),
      .rsp_last          (rsp_last)
   );

   always #10 clock = ~clock;

   // Predictor copy of the registers and the walk
   cfg_type     cfg;
   int unsigned tile_col, tile_row, sub_col, sub_row, lvl, lvl_w, lvl_h;
   bit          walk_done;

   source_unit_type source_units[$];
   texel_word_type  due_units[$];
   idle_mode_type   idle_mode = IDLE_NONE;
   int unsigned     units_walked = 0;
   int unsigned     mismatches = 0;
   int unsigned     quiet_cycles = 0;
   int unsigned     hold_left = 0;
   bit              long_hold_armed = 1'b0;
   texel_word_type  next_word;
   texel_word_type  want;
   source_unit_type next_unit;

   function automatic int unsigned capped_width();
      return (cfg.image_width > SIZE_CAP) ? SIZE_CAP : cfg.image_width;
   endfunction

   function automatic int unsigned capped_height();
      return (cfg.image_height > SIZE_CAP) ? SIZE_CAP : cfg.image_height;
   endfunction

   // Tile edge in units; compressed units are 4x4 texels, never below one
   function automatic int unsigned tile_units(logic [LOG2_W-1:0] lg);
      int unsigned b;
      b = 1 << lg;
      if (cfg.texel_format == FMT_CMPR) b = b >> 2;
      return (b == 0) ? 1 : b;
   endfunction

   function automatic void restart_walk();
      int unsigned sh;
      sh = (cfg.texel_format == FMT_CMPR) ? 2 : 0;
      tile_col  = 0;
      tile_row  = 0;
      sub_col   = 0;
      sub_row   = 0;
      lvl       = 0;
      lvl_w     = capped_width() >> sh;
      lvl_h     = capped_height() >> sh;
      walk_done = 1'b0;
   endfunction

   function automatic void apply_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] wd);
      case (idx)
         REG_TEXEL_FORMAT: cfg.texel_format      = wd[FMT_W-1:0];
         REG_IMAGE_WIDTH:  cfg.image_width       = wd[SIZE_W-1:0];
         REG_IMAGE_HEIGHT: cfg.image_height      = wd[SIZE_W-1:0];
         REG_MIP_COUNT:    cfg.mip_count         = wd[LEVEL_W-1:0];
         REG_BLOCK_W_LOG2: cfg.block_width_log2  = wd[LOG2_W-1:0];
         REG_BLOCK_H_LOG2: cfg.block_height_log2 = wd[LOG2_W-1:0];
         REG_BITS_PER_TEX: cfg.bits_per_texel    = wd[BPT_W-1:0];
         default: return;
      endcase
      restart_walk();
   endfunction

   // Place one source unit: its offset, converted data and flags, then advance the walk
   function automatic bit place_unit(input logic [DATA_W-1:0] unit, input logic src_end,
                                     output texel_word_type w);
      int unsigned     levels, tw, th, sx, sy, stp, k;
      longint unsigned pix, bpu, off, area;
      bit              cmpr, done;
      w = '0;
      if (walk_done) return 1'b0;
      levels = (cfg.mip_count > LEVEL_CAP) ? LEVEL_CAP : cfg.mip_count;
      if (levels == 0) begin
         walk_done = 1'b1;
         return 1'b0;
      end
      cmpr = (cfg.texel_format == FMT_CMPR);
      tw   = tile_units(cfg.block_width_log2);
      th   = tile_units(cfg.block_height_log2);
      sx   = (lvl_w > tw) ? lvl_w : tw;
      sy   = (lvl_h > th) ? lvl_h : th;

      pix  = 64'(tile_row + sub_row) * 64'(sx) + 64'(tile_col + sub_col);
      bpu  = 64'(cfg.bits_per_texel) * (cmpr ? 64'd16 : 64'd1);
      off  = (pix * bpu) >> 3;
      area = (64'(capped_width() >> lvl) * 64'(capped_height() >> lvl) *
              64'(cfg.bits_per_texel)) >> 3;

      case (cfg.texel_format)
         FMT_I4, FMT_I8, FMT_IA4: begin
            w.out_bytes = 4'd1;
            w.out_data  = 64'(unit[7:0]);
         end
         FMT_IA8, FMT_RGB565, FMT_RGB5A3: begin
            w.out_bytes = 4'd2;
            w.out_data  = 64'(unit[15:0]);
         end
         FMT_RGBA8: begin
            w.out_bytes = 4'd4;
            w.out_data  = 64'(unit[31:0]);
         end
         FMT_CMPR: begin
            // keep both colors, mirror the 2-bit indexes inside each index byte
            w.out_bytes = 4'd8;
            w.out_data  = unit;
            for (k = 0; k < 16; k++)
               w.out_data[2*k +: 2] = unit[2*((k/4)*4 + 3 - k%4) +: 2];
         end
         default: ;
      endcase

      w.dest_offset   = OFFSET_W'(off);
      w.mip_level     = LEVEL_W'(lvl);
      w.beyond_buffer = (off >= area);

      // advance texel, then tile, then tile row, then level
      done = 1'b0;
      stp  = (cfg.bits_per_texel == 4 && !cmpr) ? 2 : 1;
      sub_col += stp;
      if (sub_col >= tw) begin
         sub_col = 0;
         sub_row++;
         if (sub_row >= th) begin
            sub_row = 0;
            tile_col += tw;
            if (tile_col >= sx) begin
               tile_col = 0;
               tile_row += th;
               if (tile_row >= sy) begin
                  tile_row = 0;
                  lvl++;
                  lvl_w = lvl_w >> 1;
                  lvl_h = lvl_h >> 1;
                  if (lvl >= levels) done = 1'b1;
               end
            end
         end
      end
      if (src_end) done = 1'b1;
      if (done) walk_done = 1'b1;
      w.last = done;
      return 1'b1;
   endfunction

   function automatic void check_field(string name, logic [63:0] exp_val, logic [63:0] got);
      if (got !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, got);
         mismatches++;
      end
   endfunction

   function automatic bit sender_idle();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 56;
         IDLE_BOTH:   return $urandom_range(99) < 19;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stall();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(99) < 56;
         IDLE_BOTH:     return $urandom_range(99) < 19;
         default:       return 1'b0;
      endcase
   endfunction

   // Sender: predict each taken word, then offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (place_unit(req_unit_data, req_source_end, next_word)) begin
               due_units.push_back(next_word);
               units_walked++;
            end
         end
         if (!req_valid || !req_stall) begin
            if (source_units.size() != 0 && !sender_idle()) begin
               next_unit = source_units.pop_front();
               req_valid      <= 1'b1;
               req_unit_data  <= next_unit.data;
               req_source_end <= next_unit.src_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each taken result word against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_units.size() == 0) begin
               $error("result word with no unit pending, offset %0h", rsp_dest_offset);
               mismatches++;
            end else begin
               want = due_units.pop_front();
               check_field("dest_offset", want.dest_offset, rsp_dest_offset);
               check_field("out_data", want.out_data, rsp_out_data);
               check_field("out_bytes", want.out_bytes, rsp_out_bytes);
               check_field("mip_level", want.mip_level, rsp_mip_level);
               check_field("beyond_buffer", want.beyond_buffer, rsp_beyond_buffer);
               check_field("last", want.last, rsp_last);
            end
         end
         if (long_hold_armed) begin
            hold_left       = HOLD_CYCLES;
            long_hold_armed = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= receiver_stall();
         end
      end
   end

   // Watchdog: give up after a long stretch with no word moving anywhere
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void queue_unit(logic [DATA_W-1:0] data, logic src_end);
      source_unit_type u;
      u.data    = data;
      u.src_end = src_end;
      source_units.push_back(u);
   endfunction

   // Wait until every word is sent and answered, then let the pipe empty out
   task automatic drain();
      while (source_units.size() != 0 || req_valid || due_units.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      int unsigned           fw;
      logic [CSR_DATA_W-1:0] wd;
      case (idx)
         REG_TEXEL_FORMAT:                   fw = FMT_W;
         REG_MIP_COUNT:                      fw = LEVEL_W;
         REG_BLOCK_W_LOG2, REG_BLOCK_H_LOG2: fw = LOG2_W;
         REG_BITS_PER_TEX:                   fw = BPT_W;
         default:                            fw = CSR_DATA_W;
      endcase
      wd = CSR_DATA_W'(value);
      // junk above the field must be dropped by the block
      if (fw < CSR_DATA_W) wd = wd | (CSR_DATA_W'($urandom) << fw);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wd;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, wd);
      csr_valid <= 1'b0;
   endtask

   task automatic load_setup(input int unsigned fmt, input int unsigned wdt,
                             input int unsigned hgt, input int unsigned mips,
                             input int unsigned bwl, input int unsigned bhl,
                             input int unsigned bpt);
      write_reg(REG_TEXEL_FORMAT, fmt);
      write_reg(REG_IMAGE_WIDTH, wdt);
      write_reg(REG_IMAGE_HEIGHT, hgt);
      write_reg(REG_MIP_COUNT, mips);
      write_reg(REG_BLOCK_W_LOG2, bwl);
      write_reg(REG_BLOCK_H_LOG2, bhl);
      write_reg(REG_BITS_PER_TEX, bpt);
   endtask

   function automatic int unsigned random_size();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 7) return $urandom_range(16, 1);
      if (pick < 9) return $urandom_range(80, 17);
      case ($urandom_range(3))
         0:       return 0;
         1:       return 1;
         2:       return SIZE_CAP;
         default: return $urandom_range(2047, SIZE_CAP + 1);
      endcase
   endfunction

   // Mostly the native tile shape and depth of a format, sometimes anything
   task automatic random_setup();
      int unsigned fmt, bwl, bhl, bpt, mips;
      case ($urandom_range(7))
         0:       begin fmt = FMT_I4;     bwl = 3; bhl = 3; bpt = 4;  end
         1:       begin fmt = FMT_I8;     bwl = 3; bhl = 2; bpt = 8;  end
         2:       begin fmt = FMT_IA4;    bwl = 3; bhl = 2; bpt = 8;  end
         3:       begin fmt = FMT_IA8;    bwl = 2; bhl = 2; bpt = 16; end
         4:       begin fmt = FMT_RGB565; bwl = 2; bhl = 2; bpt = 16; end
         5:       begin fmt = FMT_RGB5A3; bwl = 2; bhl = 2; bpt = 16; end
         6:       begin fmt = FMT_RGBA8;  bwl = 2; bhl = 2; bpt = 32; end
         default: begin fmt = FMT_CMPR;   bwl = 3; bhl = 3; bpt = 4;  end
      endcase
      if ($urandom_range(9) == 0) fmt = $urandom_range(15);
      if ($urandom_range(5) == 0) begin
         bwl = $urandom_range(3);
         bhl = $urandom_range(3);
         bpt = $urandom_range(63);
      end
      mips = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(5, 1);
      load_setup(fmt, random_size(), random_size(), mips, bwl, bhl, bpt);
   endtask

   // Feed random words until the walk ends or the cap is reached, with a few dropped words past the end
   task automatic run_walk(input int unsigned cap);
      int unsigned sent;
      sent = 0;
      do begin
         repeat (16) queue_unit({$urandom, $urandom}, $urandom_range(63) == 0);
         sent += 16;
         while (source_units.size() != 0) @(posedge clock);
      end while (!walk_done && sent < cap);
   endtask

   initial begin
      int f;
      cfg = CFG_RESET;
      restart_walk();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset setup, data extremes
      idle_mode = IDLE_NONE;
      queue_unit('0, 1'b0);
      queue_unit('1, 1'b0);
      drain();

      // Every format code, supported or not
      for (f = 0; f < 16; f++) begin
         load_setup(f, 4, 4, 1, 2, 2, 8);
         queue_unit((f == FMT_CMPR) ? 64'h0123_4567_1B8D_E4B2 : '1, 1'b0);
         drain();
      end

      // Zero levels: the first word ends the walk silently
      load_setup(FMT_I8, 8, 8, 0, 3, 2, 8);
      queue_unit({$urandom, $urandom}, 1'b0);
      drain();

      // Oversized width and level count, zero height, deepest texel
      load_setup(FMT_RGBA8, 2047, 0, 15, 0, 1, 63);
      queue_unit({$urandom, $urandom}, 1'b0);
      queue_unit({$urandom, $urandom}, 1'b0);
      drain();

      // Source ends mid-level; the next word is dropped
      load_setup(FMT_IA8, 16, 16, 3, 3, 2, 16);
      queue_unit({$urandom, $urandom}, 1'b1);
      queue_unit({$urandom, $urandom}, 1'b0);
      drain();

      // Hold results off until input backs up, then pause the sender until all are back
      load_setup(FMT_RGB565, 64, 64, 1, 2, 2, 16);
      long_hold_armed = 1'b1;
      repeat (100) queue_unit({$urandom, $urandom}, 1'b0);
      drain();
      repeat (100) queue_unit({$urandom, $urandom}, 1'b0);
      drain();

      // Compressed walk at the deepest texel over a full-size level
      load_setup(FMT_CMPR, 1024, 1024, 1, 3, 3, 63);
      repeat (WIDE_UNITS) queue_unit({$urandom, $urandom}, 1'b0);
      drain();

      // Random setups, mostly complete walks
      units_walked = 0;
      while (units_walked < RANDOM_UNITS) begin
         idle_mode = idle_mode_type'($urandom_range(3));
         if ($urandom_range(7) == 0) write_reg(REG_UNUSED, $urandom);
         else random_setup();
         run_walk(WALK_CAP);
         drain();
      end

      if (mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
